FILE: rtl/mh2_pkg.sv
// mh2_pkg: shared constants, types and queue entry layout for the murmur2 hash unit
// no dependencies; used by every module under rtl
`default_nettype none

package mh2_pkg;

  localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
  localparam int          MIX_SHIFT   = 24;
  localparam int          FIN_SHIFT_A = 13;
  localparam int          FIN_SHIFT_B = 15;
  localparam logic [31:0] SEED_RESET  = 32'd5381;

  // queue depth between front and back, range 2 and up
  localparam int QUEUE_DEPTH = 4;

  localparam int WORD_W   = 32;
  localparam int COUNT_W  = 3;
  localparam int LENGTH_W = 31;
  localparam int TAIL_W   = 24;

  localparam logic [COUNT_W-1:0] FULL_COUNT = 3'd4;

  // how the back end folds an item into the running hash
  typedef enum logic [1:0] {
    KIND_MIX,   // full word, premixed key in k
    KIND_TAIL,  // one to three tail bytes, xor then multiply
    KIND_NONE   // empty tail, hash passes unchanged
  } kind_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_FIN_MUL,
    ST_FIN_OUT
  } back_state_t;

  typedef struct packed {
    kind_t              kind;
    logic               first;
    logic               last;
    logic [WORD_W-1:0]  seedx;  // seed xor key length
    logic [WORD_W-1:0]  k;      // word after its own mix
    logic [TAIL_W-1:0]  tail;   // tail bytes, masked by count
  } entry_t;

endpackage

`default_nettype wire

FILE: rtl/mh2_front.sv
// mh2_front: accepts items, classifies them and premixes the key word in two stages
// depends on mh2_pkg; feeds mh2_queue, credit count keeps the queue from overflowing
`default_nettype none

module mh2_front #(
  parameter int QUEUE_DEPTH = mh2_pkg::QUEUE_DEPTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [mh2_pkg::WORD_W-1:0]    seed,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [mh2_pkg::WORD_W-1:0]    data_word,
  input  wire logic [mh2_pkg::COUNT_W-1:0]   byte_count,
  input  wire logic                          first,
  input  wire logic [mh2_pkg::LENGTH_W-1:0]  total_length,
  input  wire logic                          last,
  input  wire logic                          pop,
  output logic                               push,
  output mh2_pkg::entry_t                    push_entry
);

  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

  logic [OCC_W-1:0]           occ_r, occ_nxt;
  logic                       acc;

  logic                       s1_valid_r;
  logic [mh2_pkg::WORD_W-1:0] s1_p_r, s1_p_nxt;
  mh2_pkg::entry_t            s1_e_r, s1_e_nxt;

  logic                       s2_valid_r;
  mh2_pkg::entry_t            s2_e_r, s2_e_nxt;
  logic [mh2_pkg::WORD_W-1:0] s1_xs;

  assign in_ready = (occ_r < OCC_W'(QUEUE_DEPTH));
  assign acc      = in_valid & in_ready;

  // slots held by items in the two stages or in the queue
  always_comb begin
    occ_nxt = occ_r;
    if (acc && !pop) begin
      occ_nxt = occ_r + OCC_W'(1);
    end else if (!acc && pop) begin
      occ_nxt = occ_r - OCC_W'(1);
    end
  end

  // classify item, build the tail bytes and start the word premix
  always_comb begin
    s1_p_nxt       = data_word * mh2_pkg::MIX_MUL;
    s1_e_nxt       = '0;
    s1_e_nxt.first = first;
    s1_e_nxt.last  = last;
    s1_e_nxt.seedx = seed ^ {1'b0, total_length};
    s1_e_nxt.kind  = mh2_pkg::KIND_MIX;
    if (last && (byte_count < mh2_pkg::FULL_COUNT)) begin
      if (byte_count == '0) begin
        s1_e_nxt.kind = mh2_pkg::KIND_NONE;
      end else begin
        s1_e_nxt.kind = mh2_pkg::KIND_TAIL;
      end
    end
    s1_e_nxt.tail[7:0] = data_word[7:0];
    if (byte_count >= 3'd2) begin
      s1_e_nxt.tail[15:8] = data_word[15:8];
    end
    if (byte_count >= 3'd3) begin
      s1_e_nxt.tail[23:16] = data_word[23:16];
    end
  end

  assign s1_xs = s1_p_r ^ (s1_p_r >> mh2_pkg::MIX_SHIFT);

  always_comb begin
    s2_e_nxt   = s1_e_r;
    s2_e_nxt.k = s1_xs * mh2_pkg::MIX_MUL;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r      <= '0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      occ_r      <= occ_nxt;
      s1_valid_r <= acc;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_p_r <= s1_p_nxt;
    s1_e_r <= s1_e_nxt;
    s2_e_r <= s2_e_nxt;
  end

  assign push       = s2_valid_r;
  assign push_entry = s2_e_r;

endmodule

`default_nettype wire

FILE: rtl/mh2_queue.sv
// mh2_queue: small first-in first-out store of classified items between front and back
// depends on mh2_pkg for the entry type; never pushed while full (front holds credits)
`default_nettype none

module mh2_queue #(
  parameter int QUEUE_DEPTH = mh2_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire mh2_pkg::entry_t  push_entry,
  input  wire logic             pop,
  output logic                  head_valid,
  output mh2_pkg::entry_t       head_entry
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  mh2_pkg::entry_t mem [QUEUE_DEPTH];
  mh2_pkg::entry_t head_entry_r;

  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (!push && pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  // head entry registered from the next read slot, bypassed when that slot is being written
  always_ff @(posedge clk) begin
    if (push && (wr_ptr_r == rd_ptr_nxt)) begin
      head_entry_r <= push_entry;
    end else begin
      head_entry_r <= mem[rd_ptr_nxt];
    end
  end

  assign head_valid = (count_r != '0);
  assign head_entry = head_entry_r;

endmodule

`default_nettype wire

FILE: rtl/mh2_back.sv
// mh2_back: folds queued items into the running hash, runs the final mix, holds the result
// depends on mh2_pkg; one multiply on the running hash in ST_RUN, one in ST_FIN_MUL
`default_nettype none

module mh2_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        head_valid,
  input  wire mh2_pkg::entry_t             head_entry,
  output logic                             pop,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [mh2_pkg::WORD_W-1:0]       out_data
);

  mh2_pkg::back_state_t state_r, state_nxt;

  logic [mh2_pkg::WORD_W-1:0] run_r, run_nxt;
  logic [mh2_pkg::WORD_W-1:0] hm_r, hm_nxt;
  logic [mh2_pkg::WORD_W-1:0] fm_r, fm_nxt;
  logic [mh2_pkg::WORD_W-1:0] out_data_r, out_data_nxt;
  logic                       out_valid_r, out_valid_nxt;

  logic [mh2_pkg::WORD_W-1:0] h_cur, mul_in, prod, h_new, fin_xs;
  logic                       out_free;
  logic                       load_fm, load_out;

  assign out_free = !out_valid_r || out_ready;

  // fold one entry into the hash
  always_comb begin
    h_cur  = head_entry.first ? head_entry.seedx : run_r;
    mul_in = h_cur;
    if (head_entry.kind == mh2_pkg::KIND_TAIL) begin
      mul_in = h_cur ^ {8'h00, head_entry.tail};
    end
    prod = mul_in * mh2_pkg::MIX_MUL;
    case (head_entry.kind)
      mh2_pkg::KIND_MIX:  h_new = prod ^ head_entry.k;
      mh2_pkg::KIND_TAIL: h_new = prod;
      mh2_pkg::KIND_NONE: h_new = h_cur;
      default:            h_new = h_cur;
    endcase
  end

  assign fin_xs = hm_r ^ (hm_r >> mh2_pkg::FIN_SHIFT_A);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mh2_pkg::ST_RUN: begin
        if (head_valid && head_entry.last) begin
          state_nxt = mh2_pkg::ST_FIN_MUL;
        end
      end
      mh2_pkg::ST_FIN_MUL: state_nxt = mh2_pkg::ST_FIN_OUT;
      mh2_pkg::ST_FIN_OUT: begin
        if (out_free) begin
          state_nxt = mh2_pkg::ST_RUN;
        end
      end
      default: state_nxt = mh2_pkg::ST_RUN;
    endcase
  end

  // state outputs
  always_comb begin
    pop      = 1'b0;
    load_fm  = 1'b0;
    load_out = 1'b0;
    case (state_r)
      mh2_pkg::ST_RUN:     pop      = head_valid;
      mh2_pkg::ST_FIN_MUL: load_fm  = 1'b1;
      mh2_pkg::ST_FIN_OUT: load_out = out_free;
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_comb begin
    run_nxt       = run_r;
    hm_nxt        = hm_r;
    fm_nxt        = fm_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    if (pop) begin
      if (head_entry.last) begin
        run_nxt = '0;
        hm_nxt  = h_new;
      end else begin
        run_nxt = h_new;
      end
    end
    if (load_fm) begin
      fm_nxt = fin_xs * mh2_pkg::MIX_MUL;
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_data_nxt  = fm_r ^ (fm_r >> mh2_pkg::FIN_SHIFT_B);
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mh2_pkg::ST_RUN;
      run_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      run_r       <= run_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hm_r       <= hm_nxt;
    fm_r       <= fm_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: rtl/murmur2_hash32_stream_unit.sv
// murmur2_hash32_stream_unit: top level of the streaming 32-bit murmur2 hash
// depends on mh2_pkg, mh2_front, mh2_queue and mh2_back
`default_nettype none

// Streams a key in as little-endian 32-bit words and gives out its 32-bit
// murmur2 hash. The item with tuser set opens a key and carries the key's byte
// length, which is xored with the seed register (cfg port, reset value 5381).
// Every item without tlast mixes its full word into the running hash. The item
// with tlast carries 0 to 4 valid bytes: four (or more, saturating) are mixed as
// a full word, one to three are folded in as the tail, zero adds nothing; the
// final mix follows and one result item comes out. An item without tuser
// continues from the running hash, which is zero after reset and after a key's
// last item. The stated length is trusted and never checked.
// In the back end the single multiply on the running hash folds in each word
// item and sets the pace; the item with tlast is folded, then goes through the
// final multiply and the result load, which waits until the result register
// is free. The front premixes each word in two pipelined multiply stages. A
// queue of QUEUE_DEPTH entries separates front and back; in_tready drops only
// when all of its slots are claimed. Seed writes are taken at any time with
// cfg_ready held high and should land while no key is in flight.

module murmur2_hash32_stream_unit #(
  parameter int QUEUE_DEPTH = mh2_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [31:0] data_word, [34:32] byte_count, [65:35] total_length, [71:66] zero
  input  wire logic [71:0] in_tdata,
  // [0] first
  input  wire logic [0:0]  in_tuser,
  input  wire logic        in_tlast,

  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [31:0] hash_value
  output logic [31:0]      out_tdata,

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);

  logic [mh2_pkg::WORD_W-1:0] seed_r, seed_nxt;

  // queue handshake between the two halves
  logic            push;
  mh2_pkg::entry_t push_entry;
  logic            pop;
  logic            head_valid;
  mh2_pkg::entry_t head_entry;

  // seed register, always writable
  assign cfg_ready = 1'b1;
  assign seed_nxt  = (cfg_valid && cfg_ready) ? cfg_data : seed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= mh2_pkg::SEED_RESET;
    end else begin
      seed_r <= seed_nxt;
    end
  end

  // front: accept, classify, premix word
  mh2_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .seed         (seed_r),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .data_word    (in_tdata[31:0]),
    .byte_count   (in_tdata[34:32]),
    .first        (in_tuser[0]),
    .total_length (in_tdata[65:35]),
    .last         (in_tlast),
    .pop          (pop),
    .push         (push),
    .push_entry   (push_entry)
  );

  // queue between front and back
  mh2_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  // back: running hash, final mix, result register
  mh2_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_tdata)
  );

endmodule

`default_nettype wire

FILE: bench/murmur2_hash32_stream_unit_tb.sv
// murmur2_hash32_stream_unit_tb: self-checking bench for the streaming murmur2 hash unit
// drives keys word by word, predicts each key's hash in its own model and checks every result
// depends directly on murmur2_hash32_stream_unit only

module murmur2_hash32_stream_unit_tb;

  localparam logic [31:0] HASH_MUL    = 32'h5bd1e995;
  localparam int          WORD_SHIFT  = 24;
  localparam int          AVAL_SHIFTA = 13;
  localparam int          AVAL_SHIFTB = 15;
  localparam logic [31:0] SEED_AT_RST = 32'd5381;
  localparam logic [2:0]  FULL_BYTES  = 3'd4;
  localparam int          CYCLE_LIMIT = 600000;
  localparam int          SETTLE_CYC  = 20;
  localparam int          RX_HOLD_CYC = 400;

  // one key word as the sender sees it
  typedef struct {
    logic [31:0] word;
    logic [2:0]  count;
    logic        is_first;
    logic [30:0] key_len;
    logic        is_last;
  } key_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  key_item_t   feed_q[$];         // items waiting to be offered
  logic [31:0] hash_expect_q[$];  // predicted hashes, oldest first
  key_item_t   cur_item;
  logic [31:0] seed_reg = SEED_AT_RST;
  logic [31:0] run_hash = '0;
  bit          in_took = 1'b0;
  int          tx_gap = 0;
  bit          tx_calm = 1'b0;
  bit          tx_rush = 1'b0;
  int          rx_stall = 0;
  bit          rx_calm = 1'b0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;
  int          error_count = 0;
  int          cycle_count = 0;

  murmur2_hash32_stream_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // hash predictor
  // ---------------------------------------------------------------------------

  // one full word folded into the hash: premix the word, then multiply-xor
  function automatic logic [31:0] word_mix(input logic [31:0] h, input logic [31:0] w);
    logic [31:0] k;
    k = w * HASH_MUL;
    k = k ^ (k >> WORD_SHIFT);
    k = k * HASH_MUL;
    return (h * HASH_MUL) ^ k;
  endfunction

  // advance the predicted hash by one accepted item, queue a hash on tlast
  task automatic absorb_item(input key_item_t it);
    logic [31:0] h;
    h = it.is_first ? (seed_reg ^ {1'b0, it.key_len}) : run_hash;
    if (!it.is_last) begin
      run_hash = word_mix(h, it.word);
    end else begin
      // counts above four saturate to a full word
      if (it.count >= FULL_BYTES) begin
        h = word_mix(h, it.word);
      end else begin
        // tail bytes fall through from the highest valid one down
        if (it.count >= 3'd3) h = h ^ {8'h00, it.word[23:16], 16'h0000};
        if (it.count >= 3'd2) h = h ^ {16'h0000, it.word[15:8], 8'h00};
        if (it.count >= 3'd1) begin
          h = h ^ {24'h000000, it.word[7:0]};
          h = h * HASH_MUL;
        end
      end
      h = h ^ (h >> AVAL_SHIFTA);
      h = h * HASH_MUL;
      h = h ^ (h >> AVAL_SHIFTB);
      hash_expect_q.push_back(h);
      run_hash = '0;
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("[%0t] hash check: %s", $time, what);
    error_count++;
  endtask

  // mostly back to back, sometimes a short pause, rarely a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // ---------------------------------------------------------------------------
  // input side: launch at the falling edge, take the handshake at the rising edge
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      absorb_item(cur_item);
      in_took = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (in_tvalid && !in_took) begin
        // item still waiting for in_tready, hold it
      end else if (tx_gap > 0 && !tx_rush) begin
        tx_gap--;
        in_tvalid <= 1'b0;
      end else if (feed_q.size() != 0) begin
        cur_item = feed_q.pop_front();
        in_tdata <= {6'b0, cur_item.key_len, cur_item.count, cur_item.word};
        in_tuser <= cur_item.is_first;
        in_tlast <= cur_item.is_last;
        in_tvalid <= 1'b1;
        // switch now and then between gappy and gap-free stretches
        if ($urandom_range(0, 79) == 0) tx_calm = !tx_calm;
        tx_gap = tx_calm ? 0 : pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
      in_took = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // result side: random backpressure, plus one long hold-off on request
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_req) begin
        hold_left = RX_HOLD_CYC;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 99) == 0) rx_calm = !rx_calm;
        if (!rx_calm && $urandom_range(0, 4) == 0) rx_stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (hash_expect_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %08h", out_tdata));
      end else if (out_tdata !== hash_expect_q[0]) begin
        report_mismatch($sformatf("hash_value got %08h want %08h",
                                  out_tdata, hash_expect_q[0]));
        void'(hash_expect_q.pop_front());
      end else begin
        void'(hash_expect_q.pop_front());
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  task automatic add_item(input logic [31:0] word, input logic [2:0] count,
                          input logic is_first, input logic [30:0] key_len,
                          input logic is_last);
    key_item_t it;
    it.word = word;
    it.count = count;
    it.is_first = is_first;
    it.key_len = key_len;
    it.is_last = is_last;
    feed_q.push_back(it);
  endtask

  // one key of len bytes; a noisy key lies about its length, may lose its
  // first mark, restart midway or end on any byte count
  task automatic add_key(input int len, input bit noisy);
    int          n_words;
    bit          drop_first;
    logic [30:0] stated;
    key_item_t   it;
    n_words = (len == 0) ? 1 : (len + 3) / 4;
    drop_first = noisy && ($urandom_range(0, 2) == 0);
    stated = noisy ? 31'($urandom) : 31'(len);
    for (int i = 0; i < n_words; i++) begin
      it.word = $urandom;
      it.is_first = (i == 0) && !drop_first;
      if (noisy && i != 0 && $urandom_range(0, 5) == 0) it.is_first = 1'b1;
      it.key_len = it.is_first ? stated : 31'($urandom);
      it.is_last = (i == n_words - 1);
      if (!it.is_last) it.count = 3'($urandom);
      else if (noisy) it.count = 3'($urandom_range(0, 7));
      else it.count = 3'(len - 4 * (n_words - 1));
      feed_q.push_back(it);
    end
  endtask

  task automatic add_random_keys(input int n_items);
    int queued;
    int len;
    queued = 0;
    while (queued < n_items) begin
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(41, 300) : $urandom_range(0, 40);
      add_key(len, $urandom_range(0, 4) == 0);
      queued += (len == 0) ? 1 : (len + 3) / 4;
    end
  endtask

  // sender stops until every queued item is in and every hash is out
  task automatic wait_drained();
    while (feed_q.size() != 0 || in_tvalid || hash_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic load_seed(input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    seed_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset seed; directed corners
    // no first mark straight after reset, running hash starts at zero
    add_item(32'ha5c30f11, 3'd2, 1'b0, 31'h7fffffff, 1'b1);
    // one-item keys: empty, full word, each tail size with junk above it
    add_item(32'h00000000, 3'd0, 1'b1, 31'h00000000, 1'b1);
    add_item(32'hffffffff, 3'd4, 1'b1, 31'h7fffffff, 1'b1);
    add_item(32'hffffffff, 3'd1, 1'b1, 31'h00000001, 1'b1);
    add_item(32'hffffffff, 3'd2, 1'b1, 31'h00000002, 1'b1);
    add_item(32'hffffffff, 3'd3, 1'b1, 31'h00000003, 1'b1);
    add_item(32'h00000000, 3'd4, 1'b1, 31'h00000000, 1'b1);
    // byte counts above four saturate
    add_item($urandom, 3'd5, 1'b1, 31'h00000004, 1'b1);
    add_item($urandom, 3'd6, 1'b1, 31'h00000004, 1'b1);
    add_item($urandom, 3'd7, 1'b1, 31'h00000004, 1'b1);
    // two-word key with a three-byte tail
    add_item(32'h12345678, 3'd7, 1'b1, 31'h00000007, 1'b0);
    add_item(32'hdeadbeef, 3'd3, 1'b0, 31'h00000055, 1'b1);
    // key without any first mark continues from zero
    add_item(32'h00000000, 3'd0, 1'b0, 31'h00000000, 1'b0);
    add_item(32'hffffffff, 3'd4, 1'b0, 31'h00000000, 1'b1);
    // second first mark restarts the key midway
    add_item(32'h00000001, 3'd0, 1'b1, 31'h00000009, 1'b0);
    add_item(32'h00000002, 3'd0, 1'b1, 31'h00000006, 1'b0);
    add_item(32'h00000003, 3'd2, 1'b0, 31'h00000000, 1'b1);
    // three full words, alternating bit patterns
    add_item(32'haaaaaaaa, 3'd5, 1'b1, 31'h0000000c, 1'b0);
    add_item(32'h55555555, 3'd2, 1'b0, 31'h2aaaaaaa, 1'b0);
    add_item(32'h80000001, 3'd4, 1'b0, 31'h00000000, 1'b1);
    add_random_keys(300);
    wait_drained();

    // zero seed; receiver holds off while the sender pushes without gaps,
    // so the queue fills and in_tready must drop
    load_seed(32'h00000000);
    hold_req = 1'b1;
    @(negedge clk);
    tx_rush = 1'b1;
    repeat (40) add_item($urandom, 3'd4, 1'b1, 31'h00000004, 1'b1);
    wait_drained();
    tx_rush = 1'b0;
    add_random_keys(250);
    wait_drained();

    // all-ones seed; pause in the middle until every hash is back
    load_seed(32'hffffffff);
    add_random_keys(150);
    wait_drained();
    add_random_keys(150);
    wait_drained();

    // random seeds
    repeat (3) begin
      load_seed($urandom);
      add_random_keys(360);
      wait_drained();
    end

    repeat (SETTLE_CYC) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
